>>> rtl/four_button_debounce_and_jog_control_defines.svh
// assertion macros for the four button debounce and jog control block
// used by the top level only; expects clk_i and rst_ni in scope

`ifndef FOUR_BUTTON_DEBOUNCE_AND_JOG_CONTROL_DEFINES_SVH
`define FOUR_BUTTON_DEBOUNCE_AND_JOG_CONTROL_DEFINES_SVH

// antecedent holds in this cycle, consequent holds in the same cycle
`define FBDJ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds in this cycle, consequent holds in the next cycle
`define FBDJ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fbdj_pkg.sv
// shared types and constants for the four button debounce and jog control block
// no dependencies
`timescale 1ns / 1ps

package fbdj_pkg;

  // width of tick stamps and elapsed time arithmetic
  localparam int unsigned TICK_WIDTH = 32;

  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned NUM_BTN   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_JOG_STEP       = CFG_IDX_W'(1);

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST = CFG_W'(50);
  localparam logic [CFG_W-1:0] JOG_STEP_RST       = CFG_W'(980595);

  // debouncer status codes
  typedef enum logic [1:0] {
    CODE_NONE = 2'd0,
    CODE_HIGH = 2'd1,
    CODE_LOW  = 2'd2
  } code_e;

  typedef logic [TICK_WIDTH-1:0] tick_t;

endpackage

>>> rtl/fbdj_if.sv
// handshake channel interfaces: poll items in, result items out, register writes
// depends on fbdj_pkg
`timescale 1ns / 1ps

// poll item channel
interface fbdj_in_if;
  logic                               valid;
  logic                               ready;
  logic                               btn1_level;
  logic                               btn2_level;
  logic                               btn3_level;
  logic                               btn4_level;
  logic [31:0]                        now_ticks;
  logic signed [fbdj_pkg::ANGLE_W-1:0] angle_position;

  modport source (output valid, btn1_level, btn2_level, btn3_level, btn4_level,
                  now_ticks, angle_position, input ready);
  modport sink   (input valid, btn1_level, btn2_level, btn3_level, btn4_level,
                  now_ticks, angle_position, output ready);
endinterface

// result item channel
interface fbdj_out_if;
  logic                               valid;
  logic                               ready;
  logic                               service_mode;
  logic                               drive_toggle;
  logic                               manual_active;
  logic signed [fbdj_pkg::ANGLE_W-1:0] reference_position;
  logic [1:0]                         btn1_code;
  logic [1:0]                         btn2_code;
  logic [1:0]                         btn3_code;
  logic [1:0]                         btn4_code;

  modport source (output valid, service_mode, drive_toggle, manual_active,
                  reference_position, btn1_code, btn2_code, btn3_code, btn4_code,
                  input ready);
  modport sink   (input valid, service_mode, drive_toggle, manual_active,
                  reference_position, btn1_code, btn2_code, btn3_code, btn4_code,
                  output ready);
endinterface

// register write channel
interface fbdj_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fbdj_pkg::CFG_IDX_W-1:0]   index;
  logic [fbdj_pkg::CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/fbdj_debounce.sv
// timestamp debouncer for one button: rise and fall stamps, settled level
// depends on fbdj_pkg
`timescale 1ns / 1ps

module fbdj_debounce (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  level_i,
  input  fbdj_pkg::tick_t       now_i,
  input  logic [fbdj_pkg::CFG_W-1:0] held_i,
  output fbdj_pkg::code_e       code_o
);

  logic            prior_q, prior_d;
  logic            settled_q, settled_d;
  fbdj_pkg::tick_t rise_q, rise_d;
  fbdj_pkg::tick_t fall_q, fall_d;

  fbdj_pkg::tick_t rise_stamp;
  fbdj_pkg::tick_t fall_stamp;
  fbdj_pkg::tick_t held;
  fbdj_pkg::tick_t rise_elapsed;
  fbdj_pkg::tick_t fall_elapsed;

  // stamp on a level change, then measure modular elapsed time
  always_comb begin
    rise_stamp   = (level_i && !prior_q) ? now_i : rise_q;
    fall_stamp   = (!level_i && prior_q) ? now_i : fall_q;
    held         = fbdj_pkg::TICK_WIDTH'(held_i);
    rise_elapsed = now_i - rise_stamp;
    fall_elapsed = now_i - fall_stamp;
  end

  // settle decision, clearing the opposite stamp on a new settled level
  always_comb begin
    prior_d   = level_i;
    settled_d = settled_q;
    rise_d    = rise_stamp;
    fall_d    = fall_stamp;
    code_o    = fbdj_pkg::CODE_NONE;
    if (level_i && (rise_elapsed >= held)) begin
      code_o = fbdj_pkg::CODE_HIGH;
      if (!settled_q) begin
        settled_d = 1'b1;
        fall_d    = '0;
      end
    end else if (!level_i && (fall_elapsed >= held)) begin
      code_o = fbdj_pkg::CODE_LOW;
      if (settled_q) begin
        settled_d = 1'b0;
        rise_d    = '0;
      end
    end
  end

  // button state, updated once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q   <= 1'b0;
      settled_q <= 1'b0;
      rise_q    <= '0;
      fall_q    <= '0;
    end else if (en_i) begin
      prior_q   <= prior_d;
      settled_q <= settled_d;
      rise_q    <= rise_d;
      fall_q    <= fall_d;
    end
  end

endmodule

>>> rtl/four_button_debounce_and_jog_control.sv
// Four button debouncer with service mode, drive toggle and jog reference.
// Pipeline: a poll item passes the input register, then the result register.
// Throughput: one item per cycle; a stalled result holds the input register,
// so intake stops once that register is full.
// Reset: asynchronous active low; clears all button state, the service and jog
// flags, the jog reference and both pipeline valids, and loads the register defaults.
`timescale 1ns / 1ps
`include "four_button_debounce_and_jog_control_defines.svh"

module four_button_debounce_and_jog_control (
  input  logic clk_i,
  input  logic rst_ni,
  fbdj_cfg_if.sink   cfg_i,
  fbdj_in_if.sink    in_i,
  fbdj_out_if.source out_o
);

  // configuration registers
  logic [fbdj_pkg::CFG_W-1:0] debounce_q;
  logic [fbdj_pkg::CFG_W-1:0] jog_step_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= fbdj_pkg::DEBOUNCE_TICKS_RST;
      jog_step_q <= fbdj_pkg::JOG_STEP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        fbdj_pkg::REG_DEBOUNCE_TICKS: debounce_q <= cfg_i.data;
        fbdj_pkg::REG_JOG_STEP:       jog_step_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic accept;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign accept     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register
  logic [fbdj_pkg::NUM_BTN-1:0]        level_q;
  fbdj_pkg::tick_t                     now_q;
  logic signed [fbdj_pkg::ANGLE_W-1:0] angle_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q <= {in_i.btn4_level, in_i.btn3_level, in_i.btn2_level, in_i.btn1_level};
      now_q   <= fbdj_pkg::TICK_WIDTH'(in_i.now_ticks);
      angle_q <= in_i.angle_position;
    end
  end

  // one debouncer per button
  fbdj_pkg::code_e code [fbdj_pkg::NUM_BTN];

  for (genvar b = 0; b < fbdj_pkg::NUM_BTN; b++) begin : g_btn
    fbdj_debounce u_debounce (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .level_i (level_q[b]),
      .now_i   (now_q),
      .held_i  (debounce_q),
      .code_o  (code[b])
    );
  end

  // release after press handling for service and drive buttons
  logic press3_q, press3_d;
  logic press4_q, press4_d;
  logic service_q, service_d;
  logic toggle_d;

  always_comb begin
    press3_d  = press3_q || (code[2] == fbdj_pkg::CODE_HIGH);
    service_d = service_q;
    if (press3_d && (code[2] == fbdj_pkg::CODE_LOW)) begin
      press3_d  = 1'b0;
      service_d = !service_q;
    end
    press4_d = press4_q || (code[3] == fbdj_pkg::CODE_HIGH);
    toggle_d = 1'b0;
    if (press4_d && (code[3] == fbdj_pkg::CODE_LOW)) begin
      press4_d = 1'b0;
      toggle_d = 1'b1;
    end
  end

  // jog reference from the two jog buttons
  logic                         jog_flag_q, jog_flag_d;
  logic [fbdj_pkg::ANGLE_W-1:0] jog_ref_q, jog_ref_d;
  logic [fbdj_pkg::ANGLE_W-1:0] step_ext;

  assign step_ext = fbdj_pkg::ANGLE_W'(jog_step_q);

  always_comb begin
    jog_flag_d = jog_flag_q;
    jog_ref_d  = jog_ref_q;
    if (code[0] == code[1]) begin
      jog_flag_d = 1'b0;
    end else if (code[0] == fbdj_pkg::CODE_HIGH) begin
      jog_ref_d  = angle_q + step_ext;
      jog_flag_d = 1'b1;
    end else if (code[1] == fbdj_pkg::CODE_HIGH) begin
      jog_ref_d  = angle_q - step_ext;
      jog_flag_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press3_q   <= 1'b0;
      press4_q   <= 1'b0;
      service_q  <= 1'b0;
      jog_flag_q <= 1'b0;
      jog_ref_q  <= '0;
    end else if (advance) begin
      press3_q   <= press3_d;
      press4_q   <= press4_d;
      service_q  <= service_d;
      jog_flag_q <= jog_flag_d;
      jog_ref_q  <= jog_ref_d;
    end
  end

  // result register
  logic       toggle_q;
  logic [1:0] code1_q, code2_q, code3_q, code4_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      toggle_q <= toggle_d;
      code1_q  <= code[0];
      code2_q  <= code[1];
      code3_q  <= code[2];
      code4_q  <= code[3];
    end
  end

  assign out_o.service_mode       = service_q;
  assign out_o.drive_toggle       = toggle_q;
  assign out_o.manual_active      = jog_flag_q;
  assign out_o.reference_position = jog_ref_q;
  assign out_o.btn1_code          = code1_q;
  assign out_o.btn2_code          = code2_q;
  assign out_o.btn3_code          = code3_q;
  assign out_o.btn4_code          = code4_q;

  // checks
  `FBDJ_ASSERT_IMP(a_toggle_on_release, out_valid_q && toggle_q, code4_q == fbdj_pkg::CODE_LOW, "drive toggle without settled release")
  `FBDJ_ASSERT_IMP(a_jog_codes_differ, out_valid_q && jog_flag_q, code1_q != code2_q, "jog active with equal jog codes")
  `FBDJ_ASSERT_IMP(a_service_on_release, advance && (service_d != service_q), code[2] == fbdj_pkg::CODE_LOW, "service mode flipped without release")
  `FBDJ_ASSERT_NXT(a_input_held, in_valid_q && !advance, in_valid_q, "pending input item dropped")

endmodule

>>> verif/fbdj_poll_watch.sv
// watches the poll, result and register channels of the debounce and jog block,
// predicts every result item and compares it field by field; depends on fbdj_pkg and fbdj_if
`timescale 1ns / 1ps

module fbdj_poll_watch (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbdj_cfg_if         cfg_i,
  fbdj_in_if          poll_i,
  fbdj_out_if         result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import fbdj_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic               service_mode;
    logic               drive_toggle;
    logic               manual_active;
    logic signed [31:0] reference_position;
    code_e              btn1_code;
    code_e              btn2_code;
    code_e              btn3_code;
    code_e              btn4_code;
  } poll_result_t;

  // register copies
  logic [CFG_W-1:0] settle_ticks;
  logic [CFG_W-1:0] jog_offset;

  // per button debounce state, bit/entry 0 is button one
  logic [3:0] last_level;
  logic [3:0] held_level;
  tick_t      rise_at [4];
  tick_t      fall_at [4];

  // release detection for the service and drive buttons, jog state
  logic        svc_pressed;
  logic        drv_pressed;
  logic        service_on;
  logic        jog_on;
  logic [31:0] jog_ref;

  poll_result_t expected_results[$];
  int unsigned  mismatches;
  int unsigned  results_seen;

  assign fail_count_o = mismatches;

  // one button: stamp level changes, report a settled level once it has held long enough
  function automatic code_e settle_button(int unsigned b, logic lvl, tick_t now);
    code_e code;
    tick_t hold;
    code = CODE_NONE;
    hold = tick_t'(settle_ticks);
    if (lvl != last_level[b]) begin
      if (lvl) rise_at[b] = now;
      else fall_at[b] = now;
    end
    if (lvl && (now - rise_at[b]) >= hold) begin
      if (!held_level[b]) begin
        held_level[b] = 1'b1;
        fall_at[b] = '0;
      end
      code = CODE_HIGH;
    end else if (!lvl && (now - fall_at[b]) >= hold) begin
      if (held_level[b]) begin
        held_level[b] = 1'b0;
        rise_at[b] = '0;
      end
      code = CODE_LOW;
    end
    last_level[b] = lvl;
    return code;
  endfunction

  // whole poll: service and drive buttons first, then the jog pair
  function automatic poll_result_t predict_poll(logic [3:0] lvl, tick_t now,
                                                logic [31:0] angle);
    poll_result_t r;
    code_e c1, c2, c3, c4;
    r = '0;
    c3 = settle_button(2, lvl[2], now);
    if (c3 == CODE_HIGH) svc_pressed = 1'b1;
    if (svc_pressed && c3 == CODE_LOW) begin
      svc_pressed = 1'b0;
      service_on = ~service_on;
    end
    c4 = settle_button(3, lvl[3], now);
    if (c4 == CODE_HIGH) drv_pressed = 1'b1;
    if (drv_pressed && c4 == CODE_LOW) begin
      drv_pressed = 1'b0;
      r.drive_toggle = 1'b1;
    end
    c1 = settle_button(0, lvl[0], now);
    c2 = settle_button(1, lvl[1], now);
    // equal codes drop the jog, a lone settled press moves the reference
    if (c1 == c2) begin
      jog_on = 1'b0;
    end else if (c1 == CODE_HIGH) begin
      jog_ref = angle + 32'(jog_offset);
      jog_on = 1'b1;
    end else if (c2 == CODE_HIGH) begin
      jog_ref = angle - 32'(jog_offset);
      jog_on = 1'b1;
    end
    r.service_mode       = service_on;
    r.manual_active      = jog_on;
    r.reference_position = jog_ref;
    r.btn1_code          = c1;
    r.btn2_code          = c2;
    r.btn3_code          = c3;
    r.btn4_code          = c4;
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result %0d: %s expected %0h got %0h", results_seen, field, want, got);
    end
  endtask

  // sample all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    poll_result_t want;
    if (!rst_ni) begin
      settle_ticks = DEBOUNCE_TICKS_RST;
      jog_offset   = JOG_STEP_RST;
      last_level   = '0;
      held_level   = '0;
      for (int b = 0; b < 4; b++) begin
        rise_at[b] = '0;
        fall_at[b] = '0;
      end
      svc_pressed  = 1'b0;
      drv_pressed  = 1'b0;
      service_on   = 1'b0;
      jog_on       = 1'b0;
      jog_ref      = '0;
      mismatches   = 0;
      results_seen = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_DEBOUNCE_TICKS: settle_ticks = cfg_i.data;
          REG_JOG_STEP:       jog_offset = cfg_i.data;
          default: ;
        endcase
      end
      if (poll_i.valid && poll_i.ready)
        expected_results.push_back(predict_poll(
          {poll_i.btn4_level, poll_i.btn3_level, poll_i.btn2_level, poll_i.btn1_level},
          poll_i.now_ticks, poll_i.angle_position));
      if (result_i.valid && result_i.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d arrived with no poll outstanding", results_seen);
        end else begin
          want = expected_results.pop_front();
          compare_field("service_mode", want.service_mode, result_i.service_mode);
          compare_field("drive_toggle", want.drive_toggle, result_i.drive_toggle);
          compare_field("manual_active", want.manual_active, result_i.manual_active);
          compare_field("reference_position", want.reference_position,
                        result_i.reference_position);
          compare_field("btn1_code", want.btn1_code, result_i.btn1_code);
          compare_field("btn2_code", want.btn2_code, result_i.btn2_code);
          compare_field("btn3_code", want.btn3_code, result_i.btn3_code);
          compare_field("btn4_code", want.btn4_code, result_i.btn4_code);
        end
        results_seen++;
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

>>> verif/tb_four_button_debounce_and_jog_control.sv
// top of the debounce and jog testbench: clock, reset, poll and register stimulus, verdict
// depends on fbdj_pkg, fbdj_if, fbdj_poll_watch and the block itself
`timescale 1ns / 1ps

module tb_four_button_debounce_and_jog_control;
  import fbdj_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PHASE_POLLS  = 80;
  localparam int unsigned SWAP_AT      = 140;
  localparam int unsigned CALM_AT      = 280;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned gap_pct = 17;
  int unsigned stall_pct = 81;
  int unsigned polls_sent = 0;
  int unsigned fail_count;
  int unsigned pending;

  fbdj_cfg_if cfg_ch ();
  fbdj_in_if  poll_ch ();
  fbdj_out_if result_ch ();

  four_button_debounce_and_jog_control uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (poll_ch),
    .out_o  (result_ch)
  );

  fbdj_poll_watch poll_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_ch),
    .poll_i       (poll_ch),
    .result_i     (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // result side back-pressure
  initial begin : sink_pacing
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // end the run if no channel moves an item for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // one poll item, with random idle cycles in front of it
  task automatic send_poll(logic [3:0] lvl, tick_t ticks, logic [31:0] angle);
    while ($urandom_range(0, 99) < gap_pct) begin
      poll_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    poll_ch.valid          <= 1'b1;
    poll_ch.btn1_level     <= lvl[0];
    poll_ch.btn2_level     <= lvl[1];
    poll_ch.btn3_level     <= lvl[2];
    poll_ch.btn4_level     <= lvl[3];
    poll_ch.now_ticks      <= ticks;
    poll_ch.angle_position <= angle;
    do @(posedge clk_i); while (!poll_ch.ready);
    polls_sent++;
    // idling pattern: slow sink, then slow source, then none
    if (polls_sent == SWAP_AT) begin
      gap_pct   = 81;
      stall_pct = 17;
    end else if (polls_sent == CALM_AT) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
  endtask

  task automatic wait_drained();
    poll_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // both registers, back to back, only once every result is home
  task automatic reprogram(logic [CFG_W-1:0] settle, logic [CFG_W-1:0] offset);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_DEBOUNCE_TICKS;
    cfg_ch.data  <= settle;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.index <= REG_JOG_STEP;
    cfg_ch.data  <= offset;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly a running tick count with button presses and bounces, some arbitrary polls
  task automatic run_random(int unsigned count, int unsigned hold);
    tick_t       now;
    logic [3:0]  lvl;
    logic [31:0] angle;
    int unsigned b;
    now = $urandom;
    lvl = 4'($urandom);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 12) begin
        now = $urandom;
        lvl = 4'($urandom);
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          b = $urandom_range(0, 3);
          lvl[b] = ~lvl[b];
        end
        case ($urandom_range(0, 4))
          0:       now += hold - 1;
          1:       now += hold;
          2:       now += $urandom_range(0, hold / 4);
          default: now += $urandom_range(0, 2 * hold);
        endcase
      end
      case ($urandom_range(0, 7))
        0:       angle = 32'h7FFF_FFFF;
        1:       angle = 32'h8000_0000;
        default: angle = $urandom;
      endcase
      send_poll(lvl, now, angle);
    end
  endtask

  initial begin : stimulus
    tick_t       t;
    int unsigned hold;
    rst_ni                 <= 1'b0;
    poll_ch.valid          <= 1'b0;
    poll_ch.btn1_level     <= 1'b0;
    poll_ch.btn2_level     <= 1'b0;
    poll_ch.btn3_level     <= 1'b0;
    poll_ch.btn4_level     <= 1'b0;
    poll_ch.now_ticks      <= '0;
    poll_ch.angle_position <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= REG_DEBOUNCE_TICKS;
    cfg_ch.data            <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the reset settings, tick count wraps early on
    t = 32'hFFFF_FFE0;
    send_poll(4'b0000, t, 32'h0000_0000);
    // button one: one tick short, then exactly on the debounce, jog wraps upwards
    send_poll(4'b0001, t + 1, 32'h7FFF_FFFF);
    send_poll(4'b0001, t + 50, 32'h7FFF_FFFF);
    send_poll(4'b0001, t + 51, 32'h7FFF_FFFF);
    // swap to button two, jog wraps downwards
    send_poll(4'b0010, t + 60, 32'h8000_0000);
    send_poll(4'b0010, t + 110, 32'h8000_0000);
    // both jog buttons held, then one released
    send_poll(4'b0011, t + 120, 32'h0000_0000);
    send_poll(4'b0011, t + 170, 32'h0000_0000);
    send_poll(4'b0010, t + 180, 32'h1234_5678);
    // codes differ without a settled press
    send_poll(4'b0000, t + 190, 32'h0BAD_F00D);
    send_poll(4'b0000, t + 230, 32'h0BAD_F00D);
    // service button: a bounce, then a clean press and release
    send_poll(4'b0100, t + 300, 32'h0000_0000);
    send_poll(4'b0000, t + 310, 32'h0000_0000);
    send_poll(4'b0100, t + 320, 32'h0000_0000);
    send_poll(4'b0100, t + 370, 32'h0000_0000);
    send_poll(4'b0000, t + 380, 32'h0000_0000);
    send_poll(4'b0000, t + 430, 32'h0000_0000);
    // drive button: press, release, pulse for one poll only
    send_poll(4'b1000, t + 440, 32'hFFFF_FFFF);
    send_poll(4'b1000, t + 490, 32'hFFFF_FFFF);
    send_poll(4'b0000, t + 500, 32'hFFFF_FFFF);
    send_poll(4'b0000, t + 550, 32'hFFFF_FFFF);
    send_poll(4'b0000, t + 551, 32'hFFFF_FFFF);

    // random phases over several register settings, extremes first
    reprogram(24'd1, 24'd0);
    run_random(PHASE_POLLS, 1);
    reprogram(24'hFF_FFFF, 24'hFF_FFFF);
    run_random(PHASE_POLLS, 24'hFF_FFFF);
    hold = $urandom_range(2, 300);
    reprogram(CFG_W'(hold), CFG_W'($urandom));
    run_random(PHASE_POLLS, hold);
    hold = $urandom_range(1, 24'hFF_FFFF);
    reprogram(CFG_W'(hold), CFG_W'($urandom));
    run_random(PHASE_POLLS, hold);
    reprogram(DEBOUNCE_TICKS_RST, CFG_W'($urandom));
    run_random(PHASE_POLLS, DEBOUNCE_TICKS_RST);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/fbdj_pkg.sv
rtl/fbdj_if.sv
rtl/fbdj_debounce.sv
rtl/four_button_debounce_and_jog_control.sv
verif/fbdj_poll_watch.sv
verif/tb_four_button_debounce_and_jog_control.sv
